// File: design/bfs_pkg.sv
// Shared types and constants for the character-stuffing frame builder.
// No dependencies; imported by the front end, job queue, back end and core.
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int HDR_LEN = 24;

	localparam logic [7:0] SYN      = 8'h16;
	localparam logic [7:0] SOH      = 8'h01;
	localparam logic [7:0] STX      = 8'h02;
	localparam logic [7:0] ETX      = 8'h03;
	localparam logic [7:0] CRC_BYTE = 8'h00;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_SP    = 8'h20;

	localparam logic [15:0] SRC_PORT_RST = 16'd5000;
	localparam logic [15:0] DST_PORT_RST = 16'd8080;

	typedef logic [4:0] idx_t;

	typedef enum logic [2:0] {
		REG_SRC_MAC  = 3'd0,
		REG_DST_MAC  = 3'd1,
		REG_SRC_IP   = 3'd2,
		REG_DST_IP   = 3'd3,
		REG_SRC_PORT = 3'd4,
		REG_DST_PORT = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_ONE,
		BODY_STUFF
	} body_kind_t;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_BODY,
		PH_FLUSH,
		PH_ETX,
		PH_CRC,
		PH_DONE
	} phase_t;

	// one queued job: what a single accepted byte expands to
	typedef struct packed {
		logic       hdr;
		body_kind_t kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] flush_n;
		logic [7:0] f0;
		logic [7:0] f1;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [31:0] src_mac;
		logic [31:0] dst_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} hdr_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: design/bfs_in_if.sv
// Input channel: one payload byte and its end-of-payload flag per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bfs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_payload;

	modport source(output valid, output data_byte, output end_of_payload, input ready);
	modport sink(input valid, input data_byte, input end_of_payload, output ready);
endinterface

`default_nettype wire

// File: design/bfs_out_if.sv
// Output channel: one framed byte per transfer with its markers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bfs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	modport source(output valid, output out_byte, output run_last, output frame_end,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input frame_end,
		output ready);
endinterface

`default_nettype wire

// File: design/bfs_front.sv
// Front end: accepts payload bytes, keeps the lookahead window, classifies each
// byte into a queued job. Depends on bfs_pkg and bfs_in_if.
`timescale 1ns / 1ps
`default_nettype none

module bfs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bfs_in_if.sink             in_ch,
	input  bfs_pkg::q_stat_t   q_stat,
	output logic               push,
	output bfs_pkg::cmd_t      cmd
);
	import bfs_pkg::*;

	logic       in_frame_q;
	logic [1:0] wcnt_q;
	logic [7:0] w0_q, w1_q;

	logic       accept;
	logic [1:0] eff_cnt, n_cnt;
	logic [7:0] n_w0, n_w1, c;
	logic       eop, match;
	body_kind_t kind;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.data_byte;
	assign eop         = in_ch.end_of_payload;

	always_comb begin
		eff_cnt = in_frame_q ? wcnt_q : 2'd0;
		n_w0    = w0_q;
		n_w1    = w1_q;
		n_cnt   = eff_cnt;
		kind    = BODY_NONE;
		match   = ((w0_q == CH_E) && (w1_q == CH_T) && (c == CH_X)) ||
			((w0_q == CH_D) && (w1_q == CH_L) && (c == CH_E));
		if (eff_cnt == 2'd2) begin
			if (match) begin
				kind  = BODY_STUFF;
				n_cnt = 2'd0;
			end else begin
				kind  = BODY_ONE;
				n_w0  = w1_q;
				n_w1  = c;
				n_cnt = 2'd2;
			end
		end else if (eff_cnt == 2'd1) begin
			n_w1  = c;
			n_cnt = 2'd2;
		end else begin
			n_w0  = c;
			n_cnt = 2'd1;
		end

		cmd.hdr     = !in_frame_q;
		cmd.kind    = kind;
		cmd.b0      = w0_q;
		cmd.b1      = w1_q;
		cmd.b2      = c;
		cmd.flush_n = eop ? n_cnt : 2'd0;
		cmd.f0      = n_w0;
		cmd.f1      = n_w1;
		cmd.last    = eop;

		// a byte that only fills the window yields nothing
		push = accept && (!in_frame_q || (kind != BODY_NONE) || eop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			wcnt_q     <= 2'd0;
		end else if (accept) begin
			in_frame_q <= !eop;
			wcnt_q     <= eop ? 2'd0 : n_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w0_q <= n_w0;
			w1_q <= n_w1;
		end
	end

endmodule

`default_nettype wire

// File: design/bfs_cmd_fifo.sv
// Short job queue between front and back ends.
// Depends on bfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfs_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  bfs_pkg::cmd_t      wr_cmd,
	input  wire logic          pop,
	output bfs_pkg::cmd_t      head,
	output bfs_pkg::q_stat_t   q_stat
);
	import bfs_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign q_stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

`default_nettype wire

// File: design/bfs_back.sv
// Back end: walks the queued job through header, body, flush and trailer
// phases, one output byte per transfer. Depends on bfs_pkg and bfs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bfs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bfs_pkg::hdr_cfg_t  hcfg,
	input  bfs_pkg::cmd_t      head,
	input  bfs_pkg::q_stat_t   q_stat,
	output logic               pop,
	bfs_out_if.source          out_ch
);
	import bfs_pkg::*;

	// first phase at or after 'from' that this job actually has
	function automatic phase_t first_phase(phase_t from, cmd_t c);
		phase_t r;
		r = PH_DONE;
		if (c.last && (from <= PH_CRC))                 r = PH_CRC;
		if (c.last && (from <= PH_ETX))                 r = PH_ETX;
		if ((c.flush_n != 2'd0) && (from <= PH_FLUSH))  r = PH_FLUSH;
		if ((c.kind != BODY_NONE) && (from <= PH_BODY)) r = PH_BODY;
		if (c.hdr && (from == PH_HDR))                  r = PH_HDR;
		return r;
	endfunction

	function automatic idx_t last_idx(phase_t p, cmd_t c);
		idx_t r;
		case (p)
			PH_HDR:   r = idx_t'(HDR_LEN - 1);
			PH_BODY:  r = (c.kind == BODY_STUFF) ? 5'd6 : 5'd0;
			PH_FLUSH: r = (c.flush_n == 2'd2) ? 5'd1 : 5'd0;
			default:  r = 5'd0;
		endcase
		return r;
	endfunction

	logic       started_q;
	phase_t     ph_q;
	idx_t       idx_q;

	phase_t     cur_ph, nxt_ph;
	idx_t       cur_idx;
	logic       at_end, done, xfer;
	logic [7:0] hdr_b   [HDR_LEN];
	logic [7:0] stuff_b [7];
	logic [7:0] obyte;

	always_comb begin
		hdr_b[0]  = SYN;
		hdr_b[1]  = SYN;
		hdr_b[2]  = SOH;
		for (int k = 0; k < 4; k++) begin
			hdr_b[3+k]  = hcfg.src_mac[31-8*k -: 8];
			hdr_b[7+k]  = hcfg.dst_mac[31-8*k -: 8];
			hdr_b[11+k] = hcfg.src_ip[31-8*k -: 8];
			hdr_b[15+k] = hcfg.dst_ip[31-8*k -: 8];
		end
		hdr_b[19] = hcfg.src_port[15:8];
		hdr_b[20] = hcfg.src_port[7:0];
		hdr_b[21] = hcfg.dst_port[15:8];
		hdr_b[22] = hcfg.dst_port[7:0];
		hdr_b[23] = STX;

		stuff_b[0] = CH_D;
		stuff_b[1] = CH_L;
		stuff_b[2] = CH_E;
		stuff_b[3] = CH_SP;
		stuff_b[4] = head.b0;
		stuff_b[5] = head.b1;
		stuff_b[6] = head.b2;
	end

	always_comb begin
		cur_ph  = started_q ? ph_q : first_phase(PH_HDR, head);
		cur_idx = started_q ? idx_q : 5'd0;
		at_end  = (cur_idx == last_idx(cur_ph, head));
		nxt_ph  = at_end ? first_phase(phase_t'(3'(cur_ph + 3'd1)), head) : cur_ph;
		done    = (nxt_ph == PH_DONE);

		case (cur_ph)
			PH_HDR:   obyte = hdr_b[cur_idx];
			PH_BODY:  obyte = (head.kind == BODY_STUFF) ? stuff_b[cur_idx[2:0]] : head.b0;
			PH_FLUSH: obyte = cur_idx[0] ? head.f1 : head.f0;
			PH_ETX:   obyte = ETX;
			default:  obyte = CRC_BYTE;
		endcase

		out_ch.valid     = !q_stat.empty;
		out_ch.out_byte  = obyte;
		out_ch.run_last  = done;
		out_ch.frame_end = (cur_ph == PH_CRC);

		xfer = out_ch.valid && out_ch.ready;
		pop  = xfer && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			ph_q      <= PH_HDR;
			idx_q     <= 5'd0;
		end else if (xfer) begin
			if (done) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				ph_q      <= nxt_ph;
				idx_q     <= at_end ? 5'd0 : 5'(cur_idx + 5'd1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/bisync_frame_builder_with_stuffing_core.sv
// An accepted byte's job is registered in the job queue before the back end can output it.
// Throughput: one payload byte per cycle while the job queue is not full; each output transfer
// carries one byte, and an accepted payload byte yields 0 to 27 output bytes.
// The 4-entry job queue between front and back decouples input from output stalls.
// Reset (arst_n low, async): window empty, awaiting header, queue empty,
// header registers at their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bisync_frame_builder_with_stuffing_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bfs_in_if.sink           in_ch,
	bfs_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import bfs_pkg::*;

	hdr_cfg_t hcfg_q;
	cmd_t     f_cmd, q_head;
	q_stat_t  q_stat;
	logic     q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcfg_q.src_mac  <= '0;
			hcfg_q.dst_mac  <= '0;
			hcfg_q.src_ip   <= '0;
			hcfg_q.dst_ip   <= '0;
			hcfg_q.src_port <= SRC_PORT_RST;
			hcfg_q.dst_port <= DST_PORT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_MAC:  hcfg_q.src_mac  <= cfg_data;
				REG_DST_MAC:  hcfg_q.dst_mac  <= cfg_data;
				REG_SRC_IP:   hcfg_q.src_ip   <= cfg_data;
				REG_DST_IP:   hcfg_q.dst_ip   <= cfg_data;
				REG_SRC_PORT: hcfg_q.src_port <= cfg_data[15:0];
				REG_DST_PORT: hcfg_q.dst_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	bfs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.push   (q_push),
		.cmd    (f_cmd)
	);

	bfs_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (f_cmd),
		.pop    (q_pop),
		.head   (q_head),
		.q_stat (q_stat)
	);

	bfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.hcfg   (hcfg_q),
		.head   (q_head),
		.q_stat (q_stat),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.frame_end) |-> out_ch.run_last)
		else $error("frame_end without run_last");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job queue overflow");

	a_no_output_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !out_ch.valid)
		else $error("output valid with empty job queue");

	a_pop_on_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready) |-> (q_pop == out_ch.run_last))
		else $error("job retired out of step with run_last");
`endif

endmodule

`default_nettype wire
